### rtl/qacs_pkg.sv
// Package for the quote aware command splitter: character codes, nesting
// limits and the scanner state and result types. No dependencies.
package qacs_pkg;

   // Nesting counter width and its saturation limits
   localparam int NEST_BITS = 8;
   typedef logic signed [NEST_BITS-1:0] nest_type;
   localparam nest_type NEST_MAX = nest_type'((1 << (NEST_BITS - 1)) - 1);
   localparam nest_type NEST_MIN = nest_type'(-(1 << (NEST_BITS - 1)));
   localparam nest_type NEST_ZERO = nest_type'(0);

   // Special bytes
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_OPEN   = 8'h28;
   localparam logic [7:0] CH_CLOSE  = 8'h29;
   localparam logic [7:0] CH_TICK   = 8'h60;
   localparam logic [7:0] CH_DQ     = 8'h22;
   localparam logic [7:0] CH_SQ     = 8'h27;
   localparam logic [7:0] CH_BSL    = 8'h5C;

   // Delimiter register reset value (semicolon)
   localparam logic [7:0] DELIM_RESET = 8'h3B;

   // Per-line scanner state
   typedef struct packed {
      logic       lead_mode;
      logic       token_open;
      logic       in_single_quote;
      logic       in_double_quote;
      logic       in_backtick;
      nest_type   nest_depth;
      logic [7:0] prev_byte;
      logic       prev2_backslash;
   } scan_state_type;

   localparam scan_state_type SCAN_RESET = '{
      lead_mode:       1'b1,
      token_open:      1'b0,
      in_single_quote: 1'b0,
      in_double_quote: 1'b0,
      in_backtick:     1'b0,
      nest_depth:      NEST_ZERO,
      prev_byte:       8'h00,
      prev2_backslash: 1'b0
   };

   // Marks produced for one byte
   typedef struct packed {
      logic keep;
      logic token_end;
   } scan_mark_type;

endpackage

### rtl/qacs_scan.sv
// Combinational scanner step: next line state and byte marks for one item.
// Depends on qacs_pkg.
module qacs_scan (
   input  qacs_pkg::scan_state_type state_cur,
   input  logic [7:0]               delimiter,
   input  logic [7:0]               in_byte,
   input  logic                     line_last,
   output qacs_pkg::scan_state_type state_next,
   output qacs_pkg::scan_mark_type  mark
);

   logic                     esc;
   logic                     is_quote;
   logic                     nest_open;
   logic                     no_nest;
   logic                     split;
   qacs_pkg::scan_state_type flags;

   assign esc       = (state_cur.prev_byte == qacs_pkg::CH_BSL);
   assign nest_open = (in_byte == qacs_pkg::CH_OPEN) &&
                      (state_cur.prev_byte == qacs_pkg::CH_DOLLAR) &&
                      !state_cur.prev2_backslash;
   assign is_quote  = (in_byte == qacs_pkg::CH_SQ) || (in_byte == qacs_pkg::CH_DQ);

   // Update quote, backtick and nesting flags from the byte
   always_comb begin
      flags = state_cur;
      if (nest_open) begin
         if (state_cur.nest_depth < qacs_pkg::NEST_MAX) begin
            flags.nest_depth = state_cur.nest_depth + qacs_pkg::nest_type'(1);
         end
      end else if (in_byte == qacs_pkg::CH_CLOSE && !esc) begin
         if (state_cur.nest_depth > qacs_pkg::NEST_MIN) begin
            flags.nest_depth = state_cur.nest_depth - qacs_pkg::nest_type'(1);
         end
      end else if (in_byte == qacs_pkg::CH_TICK && !esc) begin
         flags.in_backtick = !state_cur.in_backtick;
      end else if (is_quote && !esc) begin
         if (in_byte == qacs_pkg::CH_SQ && !state_cur.in_double_quote) begin
            flags.in_single_quote = !state_cur.in_single_quote;
         end
         if (in_byte == qacs_pkg::CH_DQ && !state_cur.in_single_quote) begin
            flags.in_double_quote = !state_cur.in_double_quote;
         end
      end
   end

   assign no_nest = !flags.in_single_quote && !flags.in_double_quote &&
                    !flags.in_backtick && (flags.nest_depth == qacs_pkg::NEST_ZERO);
   assign split   = !is_quote && no_nest && !esc && (in_byte == delimiter);

   // Split or keep, then clear the line on its last byte
   always_comb begin
      state_next     = flags;
      mark.keep      = !split;
      mark.token_end = split && !state_cur.lead_mode;
      if (split) begin
         state_next.lead_mode       = 1'b1;
         state_next.token_open      = 1'b0;
         state_next.prev_byte       = 8'h00;
         state_next.prev2_backslash = 1'b0;
      end else begin
         state_next.lead_mode       = 1'b0;
         state_next.token_open      = 1'b1;
         state_next.prev_byte       = in_byte;
         state_next.prev2_backslash = esc;
      end
      if (line_last) begin
         if (!split) begin
            mark.token_end = 1'b1;
         end
         state_next = qacs_pkg::SCAN_RESET;
      end
   end

endmodule

### rtl/quote_aware_command_splitter_top.sv
// Top level of the quote aware command splitter: delimiter register, line
// state, result register. Depends on qacs_pkg and qacs_scan.
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/stall    | req_in_byte, req_line_last
//  rsp     | out       | rsp_valid/stall    | rsp_out_byte, rsp_keep, rsp_token_end,
//          |           |                    | rsp_line_done
//  csr     | in        | csr_write_enable   | csr_write_data (delimiter)
//
// One byte per cycle when not stalled; each item's result follows in the next cycle.
// The rate is set by the single result register fed from the scanner logic.
// req_stall is high only while a result waits and rsp_stall holds it.
// Synchronous reset clears the line state, the result valid and sets the
// delimiter to semicolon.
module quote_aware_command_splitter_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_line_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_keep,
   output logic       rsp_token_end,
   output logic       rsp_line_done,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data
);

   logic [7:0]               delim_ff;
   qacs_pkg::scan_state_type state_ff;
   qacs_pkg::scan_state_type state_in;
   qacs_pkg::scan_mark_type  mark;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic [7:0]               rsp_byte_ff;
   qacs_pkg::scan_mark_type  rsp_mark_ff;
   logic                     rsp_done_ff;
   logic                     accept;

   assign req_stall    = rsp_valid_ff && rsp_stall;
   assign accept       = req_valid && !req_stall;
   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   // Delimiter register
   always_ff @(posedge clock) begin
      if (reset) begin
         delim_ff <= qacs_pkg::DELIM_RESET;
      end else if (csr_write_enable) begin
         delim_ff <= csr_write_data;
      end
   end

   qacs_scan u_scan (
      .state_cur  (state_ff),
      .delimiter  (delim_ff),
      .in_byte    (req_in_byte),
      .line_last  (req_line_last),
      .state_next (state_in),
      .mark       (mark)
   );

   // Advance line state on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= qacs_pkg::SCAN_RESET;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   // Result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load result payload; hold it while stalled
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_byte_ff <= req_in_byte;
         rsp_mark_ff <= mark;
         rsp_done_ff <= req_line_last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_byte_ff;
   assign rsp_keep      = rsp_mark_ff.keep;
   assign rsp_token_end = rsp_mark_ff.token_end;
   assign rsp_line_done = rsp_done_ff;

   // An open token and lead mode exclude each other
   a_open_vs_lead: assert property (@(posedge clock) disable iff (reset)
      state_ff.token_open != state_ff.lead_mode)
      else $error("token_open and lead_mode agree");

   // The last byte of a line returns the line state to reset
   a_line_clear: assert property (@(posedge clock) disable iff (reset)
      accept && req_line_last |=> state_ff == qacs_pkg::SCAN_RESET)
      else $error("line state not cleared after last byte");

   // Only a delimiter byte is ever dropped
   a_drop_delim: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_keep |-> rsp_out_byte == delim_ff)
      else $error("dropped byte is not the delimiter");

   // A non-delimiter byte is always kept
   a_keep_other: assert property (@(posedge clock) disable iff (reset)
      accept && req_in_byte != delim_ff |=> rsp_valid && rsp_keep)
      else $error("non-delimiter byte dropped");

endmodule
